// ===== rtl/core/scf_pkg.sv =====
// Shared types and constants for the servo command framer.
// No dependencies; imported by every module of the block.
package scf_pkg;

  typedef enum logic [2:0] {
    ACT_SET_POS      = 3'd0,
    ACT_SET_ANGLE    = 3'd1,
    ACT_ENABLE       = 3'd2,
    ACT_REQ_POS      = 3'd3,
    ACT_INIT         = 3'd4,
    ACT_DECODE_REPLY = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    KIND_TX  = 2'd0,
    KIND_POS = 2'd1,
    KIND_ERR = 2'd2
  } kind_e;

  // What the back end has to emit for one queued word
  typedef enum logic [2:0] {
    FRM_POSITION,
    FRM_ENABLE,
    FRM_REQUEST,
    FRM_INIT,
    FRM_REPLY,
    FRM_ERROR
  } frame_e;

  localparam logic [7:0] CmdSetPos = 8'hE0;
  localparam logic [7:0] CmdEnable = 8'hC0;
  localparam logic [7:0] CmdReqPos = 8'hA0;
  localparam logic [7:0] CmdInit   = 8'h80;

  localparam logic signed [8:0] AngleOffset = 9'sd90;
  localparam logic [7:0]        AngleSpan   = 8'd180;

  // floor(p / 180) == (p * RecipAngle) >> RecipShift for p <= 180 * 8191
  localparam int unsigned RecipShift = 28;
  localparam logic [20:0] RecipAngle = 21'd1491309;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    frame_e      frame;
    logic [4:0]  channel;
    logic [12:0] position;
    logic [7:0]  data;
    logic [13:0] tag;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Index of the final byte of a frame
  function automatic logic [1:0] frame_last_idx(frame_e frame);
    logic [1:0] idx;
    unique case (frame)
      FRM_POSITION: idx = 2'd3;
      FRM_ENABLE:   idx = 2'd1;
      FRM_INIT:     idx = 2'd2;
      default:      idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/core/scf_front.sv =====
// Front end: classifies an accepted command and builds its queue word.
// Depends on scf_pkg.
module scf_front (
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        action_i,
  input  logic [4:0]        channel_i,
  input  logic [12:0]       position_i,
  input  logic signed [7:0] angle_i,
  input  logic [7:0]        speed_i,
  input  logic [7:0]        on_off_i,
  input  logic [7:0]        reply_high_i,
  input  logic [7:0]        reply_low_i,
  output logic              push_o,
  output scf_pkg::entry_t   entry_o
);
  import scf_pkg::*;

  logic signed [8:0] angle_sum;
  logic              angle_ok;
  logic [7:0]        angle_x;
  logic [20:0]       scaled;
  logic [41:0]       prod;
  logic [12:0]       apos;
  logic              take;

  assign take      = start && !busy;
  assign angle_sum = {angle_i[7], angle_i} + AngleOffset;
  assign angle_ok  = !angle_sum[8] && (angle_sum[7:0] <= AngleSpan);
  assign angle_x   = angle_sum[7:0];
  // x * 8191 as a shift and subtract
  assign scaled    = {angle_x, 13'b0} - 21'(angle_x);
  assign prod      = 42'(scaled) * 42'(RecipAngle);
  assign apos      = prod[RecipShift+12:RecipShift];

  always_comb begin
    push_o           = 1'b0;
    entry_o.frame    = FRM_POSITION;
    entry_o.channel  = channel_i;
    entry_o.position = position_i;
    entry_o.data     = speed_i;
    entry_o.tag      = '0;
    unique case (action_e'(action_i))
      ACT_SET_POS: begin
        push_o = take;
      end
      ACT_SET_ANGLE: begin
        push_o = take;
        if (angle_ok) begin
          entry_o.position = apos;
          entry_o.tag      = {1'b0, apos};
        end else begin
          entry_o.frame = FRM_ERROR;
        end
      end
      ACT_ENABLE: begin
        push_o        = take;
        entry_o.frame = FRM_ENABLE;
        entry_o.data  = on_off_i;
      end
      ACT_REQ_POS: begin
        push_o        = take;
        entry_o.frame = FRM_REQUEST;
      end
      ACT_INIT: begin
        push_o        = take;
        entry_o.frame = FRM_INIT;
      end
      ACT_DECODE_REPLY: begin
        push_o        = take;
        entry_o.frame = FRM_REPLY;
        entry_o.tag   = {reply_high_i, reply_low_i[5:0]};
      end
      // unused codes: drop the command
      default: push_o = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/scf_queue.sv =====
// Two-word queue between the front end and the frame sequencer.
// Depends on scf_pkg.
module scf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scf_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output scf_pkg::head_t  head_o
);
  import scf_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/scf_back.sv =====
// Back end: walks a valid head word bytewise and registers one result a cycle.
// Depends on scf_pkg.
module scf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scf_pkg::head_t head_i,
  output logic           pop_o,
  output logic           out_strobe_o,
  output logic [1:0]     kind_o,
  output logic [7:0]     tx_byte_o,
  output logic [13:0]    position_value_o,
  output logic           last_o
);
  import scf_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        is_last;
  kind_e       kind;
  logic [7:0]  byte_val;
  logic [13:0] pv;
  entry_t      e;

  assign e       = head_i.entry;
  assign is_last = (idx_q == frame_last_idx(e.frame));
  assign pop_o   = head_i.valid && is_last;

  always_comb begin
    kind     = KIND_TX;
    byte_val = '0;
    pv       = '0;
    unique case (e.frame)
      FRM_POSITION: begin
        pv = e.tag;
        case (idx_q)
          2'd0:    byte_val = CmdSetPos | {3'b0, e.channel};
          2'd1:    byte_val = {1'b0, e.position[12:6]};
          2'd2:    byte_val = {2'b0, e.position[5:0]};
          default: byte_val = e.data;
        endcase
      end
      FRM_ENABLE: begin
        byte_val = (idx_q == 2'd0) ? (CmdEnable | {3'b0, e.channel}) : e.data;
      end
      FRM_REQUEST: begin
        byte_val = CmdReqPos | {3'b0, e.channel};
      end
      FRM_INIT: begin
        byte_val = (idx_q == 2'd0) ? (CmdInit | {3'b0, e.channel}) : 8'h00;
      end
      FRM_REPLY: begin
        kind = KIND_POS;
        pv   = e.tag;
      end
      FRM_ERROR: begin
        kind = KIND_ERR;
      end
      default: kind = KIND_ERR;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (head_i.valid) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      out_strobe_o <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      out_strobe_o <= head_i.valid;
    end
  end

  // result payload: hold whatever the last strobe showed when idle
  always_ff @(posedge clk_i) begin
    if (head_i.valid) begin
      kind_o           <= kind;
      tx_byte_o        <= byte_val;
      position_value_o <= pv;
      last_o           <= is_last;
    end
  end

endmodule

// ===== rtl/core/servo_command_framer.sv =====
// Top level of the servo command framer: front end, word queue, frame sequencer.
// Depends on scf_pkg, scf_front, scf_queue, scf_back.
//
// Usage:
//   Command channel: present action_i and its fields with start high; the
//   command is taken at a rising edge where start is high and busy is low.
//   busy is high while the two-word queue is full.
//   Result channel: each result shows for one cycle with out_strobe_o high;
//   a frame gives one result per transmit byte in sending order, last_o on
//   the final one. Decoded replies and angle errors give a single result.
//   Unused action codes are taken and give no result.
// With the queue empty, a command is stored in the queue at the edge that took
//   it, and its first result is then registered in the back end's outputs.
// Throughput: the sequencer emits one byte a cycle while a word is queued; a
//   frame has 1 to 4 results, and position frames have 4.
//   The front end works ahead into the queue while the sequencer is busy.
// The angle scaling is one 21x21 multiply by a reciprocal in the front end.
// Reset empties the queue and clears the strobe; the receiver cannot stall,
//   so results leave at the sequencer's pace.
module servo_command_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        action_i,
  input  logic [4:0]        channel_i,
  input  logic [12:0]       position_i,
  input  logic signed [7:0] angle_i,
  input  logic [7:0]        speed_i,
  input  logic [7:0]        on_off_i,
  input  logic [7:0]        reply_high_i,
  input  logic [7:0]        reply_low_i,
  output logic              out_strobe_o,
  output logic [1:0]        kind_o,
  output logic [7:0]        tx_byte_o,
  output logic [13:0]       position_value_o,
  output logic              last_o
);
  import scf_pkg::*;

  logic   push;
  entry_t entry;
  logic   pop;
  head_t  head;

  scf_front u_front (
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .channel_i    (channel_i),
    .position_i   (position_i),
    .angle_i      (angle_i),
    .speed_i      (speed_i),
    .on_off_i     (on_off_i),
    .reply_high_i (reply_high_i),
    .reply_low_i  (reply_low_i),
    .push_o       (push),
    .entry_o      (entry)
  );

  scf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (busy),
    .head_o  (head)
  );

  scf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .out_strobe_o     (out_strobe_o),
    .kind_o           (kind_o),
    .tx_byte_o        (tx_byte_o),
    .position_value_o (position_value_o),
    .last_o           (last_o)
  );

endmodule

// ===== rtl/core/scf_checker.sv =====
// Port-level checks on the servo command framer's result stream.
// Depends on scf_pkg; bound to servo_command_framer.
module scf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_strobe_o,
  input logic [1:0]  kind_o,
  input logic [7:0]  tx_byte_o,
  input logic [13:0] position_value_o,
  input logic        last_o
);
  import scf_pkg::*;

  // bytes of one frame leave in consecutive cycles
  a_frame_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_o |=> out_strobe_o)
    else $error("frame broken by an idle cycle");

  // decoded replies and angle errors are single results
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && (kind_o != KIND_TX) |-> last_o)
    else $error("non-byte result without last");

  a_err_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && (kind_o == KIND_ERR) |-> (tx_byte_o == 8'h00) && (position_value_o == '0))
    else $error("angle error carries payload");

  // a frame keeps its kind and its position tag over all its bytes
  a_frame_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_o |=>
      (kind_o == $past(kind_o)) && (position_value_o == $past(position_value_o)))
    else $error("frame changed kind or position tag midway");

endmodule

bind servo_command_framer scf_checker u_scf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_strobe_o     (out_strobe_o),
  .kind_o           (kind_o),
  .tx_byte_o        (tx_byte_o),
  .position_value_o (position_value_o),
  .last_o           (last_o)
);
